// ===== rtl/core/dcqs_pkg.sv =====
// ----------------------------------------------------------------------------
// dcqs_pkg
// Shared types, codes and helpers for the DMA command queue splitter.
// ----------------------------------------------------------------------------
package dcqs_pkg;

    localparam int DEF_RING_DEPTH = 128;
    localparam int DEF_PRIO_DEPTH = 8;

    // 128 KiB source window, held as an 18-bit quantity
    localparam logic [17:0] BOUNDARY      = 18'h20000;
    localparam logic [7:0]  SRC_FILL_CODE = 8'h80;
    localparam logic [7:0]  SRC_COPY_CODE = 8'hC0;

    typedef enum logic [1:0] {
        KIND_XFER   = 2'd0,
        KIND_SPRITE = 2'd1,
        KIND_FILL   = 2'd2,
        KIND_COPY   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        RES_STORED       = 3'd0,
        RES_STORED_SPLIT = 3'd1,
        RES_PART_DROPPED = 3'd2,
        RES_DROPPED_FULL = 3'd3,
        RES_POPPED       = 3'd4,
        RES_EMPTY        = 3'd5
    } t_result;

    // One stored command
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  target;
        logic [15:0] dest;
        logic [23:0] source_reg;
        logic [15:0] length;
        logic [7:0]  stride;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic wr_up;
        logic wr_low;
        logic load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_pop;
        logic in_split;
        logic out_free;
    } t_dp_status;

    function automatic logic [23:0] source_reg(input logic [1:0] kind,
                                               input logic [23:0] src);
        logic [23:0] res;
        begin
            unique case (kind)
                KIND_FILL: res = {SRC_FILL_CODE, 8'h00, src[7:0]};
                KIND_COPY: res = {SRC_COPY_CODE, src[15:0]};
                default:   res = {1'b0, src[23:1]};
            endcase
            return res;
        end
    endfunction

endpackage

// ===== rtl/core/dcqs_ram.sv =====
// ----------------------------------------------------------------------------
// dcqs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dcqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/dcqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcqs_ctrl
// Sequencer: accepts one beat, steps the queue writes or the read, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
module dcqs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  dcqs_pkg::t_dp_status i_status,
    output dcqs_pkg::t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WR_UP  = 4'b0010,
        S_WR_LOW = 4'b0100,
        S_RD     = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_ready       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    if (i_status.in_pop) begin
                        n_state = S_RD;
                    end else if (i_status.in_split) begin
                        n_state = S_WR_UP;
                    end else begin
                        n_state = S_WR_LOW;
                    end
                end
            end
            S_WR_UP: begin
                o_cmd.wr_up = 1'b1;
                n_state     = S_WR_LOW;
            end
            S_WR_LOW: begin
                // hold the last write until the result can be taken
                if (i_status.out_free) begin
                    o_cmd.wr_low = 1'b1;
                    o_cmd.load   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RD: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/dcqs_datapath.sv =====
// ----------------------------------------------------------------------------
// dcqs_datapath
// Command registers, boundary split arithmetic, ring and priority stores with
// their indices, and the output register.
// ----------------------------------------------------------------------------
module dcqs_datapath #(
    parameter int RING_DEPTH = dcqs_pkg::DEF_RING_DEPTH,
    parameter int PRIO_DEPTH = dcqs_pkg::DEF_PRIO_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dcqs_pkg::t_cmd       i_cmd,
    output dcqs_pkg::t_dp_status o_status,
    input  logic                 i_mode,
    input  logic [1:0]           i_kind,
    input  logic [1:0]           i_target,
    input  logic [15:0]          i_dest_address,
    input  logic [23:0]          i_source,
    input  logic [15:0]          i_length,
    input  logic [7:0]           i_stride,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [2:0]           o_out_status,
    output logic [1:0]           o_out_kind,
    output logic [1:0]           o_out_target,
    output logic [15:0]          o_out_dest,
    output logic [23:0]          o_out_source_reg,
    output logic [15:0]          o_out_length,
    output logic [7:0]           o_out_stride,
    output logic                 o_out_priority
);

    localparam int RING_IW = $clog2(RING_DEPTH);
    localparam int PRIO_CW = $clog2(PRIO_DEPTH + 1);
    localparam int PRIO_AW = (PRIO_DEPTH > 1) ? $clog2(PRIO_DEPTH) : 1;
    localparam int ENTRY_W = $bits(dcqs_pkg::t_entry);

    // captured command
    logic        r_mode;
    logic [1:0]  r_kind;
    logic [1:0]  r_target;
    logic [15:0] r_dest;
    logic [23:0] r_src;
    logic [15:0] r_len;
    logic [7:0]  r_stride;
    logic [17:0] r_limit;
    logic        r_split;
    logic        r_up_ok;
    logic        r_pop_prio;
    logic        r_pop_hit;

    logic [RING_IW-1:0] r_ring_wr;
    logic [RING_IW-1:0] r_ring_rd;
    logic [PRIO_CW-1:0] r_prio_cnt;
    logic [PRIO_CW-1:0] r_prio_rd;

    logic                 r_out_valid;
    dcqs_pkg::t_result    r_out_status;
    dcqs_pkg::t_entry     r_out_entry;
    logic                 r_out_priority;

    logic [17:0]        in_limit;
    logic [16:0]        half;
    logic               in_split;
    logic               out_free;
    logic               wr_any;
    logic               is_prio;
    logic               ring_full;
    logic               prio_full;
    logic               store_ok;
    logic               prio_we;
    logic               ring_we;
    logic [RING_IW-1:0] ring_wr_next;
    logic [RING_IW-1:0] ring_rd_next;
    logic [PRIO_CW-1:0] prio_rd_inc;
    logic               pop_acc;
    logic               prio_avail;
    logic               ring_avail;
    logic               prio_rd_en;
    logic               ring_rd_en;
    logic [15:0]        e_dest;
    logic [23:0]        e_src;
    logic [15:0]        e_len;
    dcqs_pkg::t_entry   wr_entry;
    dcqs_pkg::t_entry   prio_q;
    dcqs_pkg::t_entry   ring_q;
    dcqs_pkg::t_entry   rd_entry;
    dcqs_pkg::t_result  n_result;

    // boundary split decision on the incoming beat
    assign in_limit = dcqs_pkg::BOUNDARY - {1'b0, i_source[16:0]};
    assign in_split = !i_kind[1] && ({1'b0, i_length} > in_limit[17:1]);
    assign half     = r_limit[17:1];

    assign out_free = !r_out_valid || i_out_ready;

    assign o_status.in_pop   = i_mode;
    assign o_status.in_split = in_split;
    assign o_status.out_free = out_free;

    // store side
    assign wr_any       = i_cmd.wr_up || i_cmd.wr_low;
    assign is_prio      = (r_kind == dcqs_pkg::KIND_SPRITE);
    assign ring_wr_next = (r_ring_wr == RING_IW'(RING_DEPTH - 1)) ? '0 : r_ring_wr + 1'b1;
    assign ring_full    = (ring_wr_next == r_ring_rd);
    assign prio_full    = (r_prio_cnt >= PRIO_CW'(PRIO_DEPTH));
    assign store_ok     = is_prio ? !prio_full : !ring_full;
    assign prio_we      = wr_any && is_prio && !prio_full;
    assign ring_we      = wr_any && !is_prio && !ring_full;

    // upper part first, then the lower part (or the whole command)
    always_comb begin
        if (i_cmd.wr_up) begin
            e_dest = r_dest + r_limit[15:0];
            e_src  = r_src + {6'b0, r_limit};
            e_len  = r_len - half[15:0];
        end else begin
            e_dest = r_dest;
            e_src  = r_src;
            e_len  = r_split ? half[15:0] : r_len;
        end
        wr_entry.kind       = r_kind;
        wr_entry.target     = r_target;
        wr_entry.dest       = e_dest;
        wr_entry.source_reg = dcqs_pkg::source_reg(r_kind, e_src);
        wr_entry.length     = e_len;
        wr_entry.stride     = r_stride;
    end

    // pop side: priority store first, then the ring
    assign pop_acc      = i_cmd.accept && i_mode;
    assign prio_avail   = (r_prio_rd < r_prio_cnt);
    assign ring_avail   = (r_ring_rd != r_ring_wr);
    assign prio_rd_en   = pop_acc && prio_avail;
    assign ring_rd_en   = pop_acc && !prio_avail && ring_avail;
    assign prio_rd_inc  = r_prio_rd + 1'b1;
    assign ring_rd_next = (r_ring_rd == RING_IW'(RING_DEPTH - 1)) ? '0 : r_ring_rd + 1'b1;

    dcqs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ring_we),
        .i_wr_addr (r_ring_wr),
        .i_wr_data (wr_entry),
        .i_rd_en   (ring_rd_en),
        .i_rd_addr (r_ring_rd),
        .o_rd_data (ring_q)
    );

    dcqs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PRIO_DEPTH)
    ) u_prio_ram (
        .i_clk     (i_clk),
        .i_wr_en   (prio_we),
        .i_wr_addr (r_prio_cnt[PRIO_AW-1:0]),
        .i_wr_data (wr_entry),
        .i_rd_en   (prio_rd_en),
        .i_rd_addr (r_prio_rd[PRIO_AW-1:0]),
        .o_rd_data (prio_q)
    );

    assign rd_entry = r_pop_prio ? prio_q : ring_q;

    always_comb begin
        if (r_mode) begin
            n_result = r_pop_hit ? dcqs_pkg::RES_POPPED : dcqs_pkg::RES_EMPTY;
        end else if (r_split) begin
            if (r_up_ok && store_ok) begin
                n_result = dcqs_pkg::RES_STORED_SPLIT;
            end else if (r_up_ok || store_ok) begin
                n_result = dcqs_pkg::RES_PART_DROPPED;
            end else begin
                n_result = dcqs_pkg::RES_DROPPED_FULL;
            end
        end else begin
            n_result = store_ok ? dcqs_pkg::RES_STORED : dcqs_pkg::RES_DROPPED_FULL;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode   <= i_mode;
            r_kind   <= i_kind;
            r_target <= i_target;
            r_dest   <= i_dest_address;
            r_src    <= i_source;
            r_len    <= i_length;
            r_stride <= i_stride;
            r_limit  <= in_limit;
            r_split  <= in_split;
        end
        if (pop_acc) begin
            r_pop_prio <= prio_avail;
            r_pop_hit  <= prio_avail || ring_avail;
        end
        if (i_cmd.wr_up) begin
            r_up_ok <= store_ok;
        end
        if (i_cmd.load) begin
            r_out_status <= n_result;
            if (r_mode && r_pop_hit) begin
                r_out_entry    <= rd_entry;
                r_out_priority <= r_pop_prio;
            end else begin
                r_out_entry    <= '0;
                r_out_priority <= 1'b0;
            end
        end
    end

    // queue indices and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_wr   <= '0;
            r_ring_rd   <= '0;
            r_prio_cnt  <= '0;
            r_prio_rd   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ring_we) begin
                r_ring_wr <= ring_wr_next;
            end
            if (ring_rd_en) begin
                r_ring_rd <= ring_rd_next;
            end
            if (prio_we) begin
                r_prio_cnt <= r_prio_cnt + 1'b1;
            end else if (prio_rd_en) begin
                // empty the priority store once its last entry is taken
                if (prio_rd_inc >= r_prio_cnt) begin
                    r_prio_rd  <= '0;
                    r_prio_cnt <= '0;
                end else begin
                    r_prio_rd <= prio_rd_inc;
                end
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_status     = r_out_status;
    assign o_out_kind       = r_out_entry.kind;
    assign o_out_target     = r_out_entry.target;
    assign o_out_dest       = r_out_entry.dest;
    assign o_out_source_reg = r_out_entry.source_reg;
    assign o_out_length     = r_out_entry.length;
    assign o_out_stride     = r_out_entry.stride;
    assign o_out_priority   = r_out_priority;

endmodule

// ===== rtl/core/dma_command_queue_splitter_core.sv =====
// ----------------------------------------------------------------------------
// dma_command_queue_splitter_core
// Video DMA command queue: ring plus priority store, with 128 KiB split.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_*: one beat is either an enqueue (tuser mode = 0)
//   or a pop (mode = 1). Master channel m_axis_*: exactly one result beat per
//   accepted input beat, in order, carrying the status and, for a pop that
//   hit, the stored command.
//   Sequencing: one beat is worked at a time. An enqueue without split or a
//   pop loads the result register from the state after acceptance (the pop
//   reads the store memory on the accepting edge), a split enqueue only after
//   its upper part is written (one store write per part). The next beat is
//   accepted once the sequencer is back in idle after the load.
//   Sprite transfers go to the priority store, the rest to the ring, which
//   holds RING_DEPTH - 1 commands. Pops drain the priority store first.
//   Reset empties both stores by clearing the indices and counts only, and
//   drops any pending result.
//   Receiver stall: the result register holds its beat; the sequencer waits
//   with its final step until the register is free and then accepts again.
// ----------------------------------------------------------------------------
module dma_command_queue_splitter_core #(
    parameter int RING_DEPTH = dcqs_pkg::DEF_RING_DEPTH,
    parameter int PRIO_DEPTH = dcqs_pkg::DEF_PRIO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // target[1:0], dest_address[17:2], source[41:18], length[57:42],
    // stride[65:58], zero pad[71:66]
    input  logic [71:0] s_axis_tdata,
    // mode[0], kind[2:1]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_target[1:0], out_dest[17:2], out_source_reg[41:18],
    // out_length[57:42], out_stride[65:58], out_priority[66], zero pad[71:67]
    output logic [71:0] m_axis_tdata,
    // status[2:0], out_kind[4:3]
    output logic [4:0]  m_axis_tuser
);

    dcqs_pkg::t_cmd       cmd;
    dcqs_pkg::t_dp_status dp_status;

    logic [2:0]  out_status;
    logic [1:0]  out_kind;
    logic [1:0]  out_target;
    logic [15:0] out_dest;
    logic [23:0] out_source_reg;
    logic [15:0] out_length;
    logic [7:0]  out_stride;
    logic        out_priority;

    dcqs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (dp_status),
        .o_cmd    (cmd)
    );

    dcqs_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .PRIO_DEPTH (PRIO_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (dp_status),
        .i_mode           (s_axis_tuser[0]),
        .i_kind           (s_axis_tuser[2:1]),
        .i_target         (s_axis_tdata[1:0]),
        .i_dest_address   (s_axis_tdata[17:2]),
        .i_source         (s_axis_tdata[41:18]),
        .i_length         (s_axis_tdata[57:42]),
        .i_stride         (s_axis_tdata[65:58]),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_out_status     (out_status),
        .o_out_kind       (out_kind),
        .o_out_target     (out_target),
        .o_out_dest       (out_dest),
        .o_out_source_reg (out_source_reg),
        .o_out_length     (out_length),
        .o_out_stride     (out_stride),
        .o_out_priority   (out_priority)
    );

    assign m_axis_tdata = {5'b0, out_priority, out_stride, out_length,
                           out_source_reg, out_dest, out_target};
    assign m_axis_tuser = {out_kind, out_status};

endmodule
